>>> sv/page_frame_allocator_unit_defines.svh
// Assertion macros of the page frame allocator RTL.
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PFA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pfa_pkg.sv
// Types and fixed constants of the page frame allocator.
package pfa_pkg;

  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int PID_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int VPAGE_W   = 6;
  localparam int FQ_W      = 6;
  localparam int STATUS_W  = 2;
  localparam int TFRAME_W  = 6;
  localparam int MAPPED_W  = 8;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 24;
  localparam int PID_COUNT = 1 << PID_W;

  // Free-map mark of a frame in use
  localparam logic [BYTE_W-1:0] USED_MARK = 8'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_TABLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_DATA  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_NEW    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WR_SLOT,
    ST_WR_ENTRY,
    ST_LK_SLOT,
    ST_LK_TABLE,
    ST_LK_MAP,
    ST_Q_READ,
    ST_Q_CAP,
    ST_DONE
  } state_t;

endpackage

>>> sv/page_frame_allocator_unit.sv
// A new process scans with one free-map read per cycle, pausing for the write after each hit.
// Lookup (slot, table entry, mapped frame) and frame query are bound by the registered RAM read.
// One command is worked at a time; the next is taken once the sequencer is idle again.
// A result waits in an output register, so the sequencer goes idle while it is unread.
// After rst the RAM is swept once, one byte per cycle, with tready low.
// rst is synchronous and clears the sequencer and output valid.
module page_frame_allocator_unit #(
  parameter int PAGE_BYTES    = 256,
  parameter int FRAME_COUNT   = 64,
  parameter int PROCESS_SLOTS = 64,
  parameter int RAM_BYTES     = 16384
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // command[1:0], process_id[7:2], data_page_count[14:8], virtual_page[20:15],
  // frame_query[26:21], zero[31:27]
  input  logic [pfa_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], table_frame[7:2], pages_granted[14:8], mapped_frame[22:15],
  // frame_in_use[23]
  output logic [pfa_pkg::OUT_W-1:0]   m_axis_tdata
);

`include "page_frame_allocator_unit_defines.svh"

  localparam int AW     = $clog2(RAM_BYTES);
  localparam int SW     = $clog2(FRAME_COUNT + 1);
  localparam int PROD_W = pfa_pkg::BYTE_W + $clog2(PAGE_BYTES) + 1;

  pfa_pkg::state_t state, state_next;

  logic [pfa_pkg::PID_W-1:0]    pid_reg;
  logic [pfa_pkg::COUNT_W-1:0]  count_reg;
  logic [pfa_pkg::VPAGE_W-1:0]  vpage_reg;
  logic [pfa_pkg::FQ_W-1:0]     fq_reg;
  logic                         phase_data;
  logic [SW-1:0]                scan_f;
  logic [SW-1:0]                rd_f;
  logic                         rd_v;
  logic [pfa_pkg::BYTE_W-1:0]   table_reg;
  logic [SW-1:0]                data_frame;
  logic [pfa_pkg::STATUS_W-1:0] res_status;
  logic [pfa_pkg::TFRAME_W-1:0] res_tframe;
  logic [pfa_pkg::COUNT_W-1:0]  res_granted;
  logic [pfa_pkg::MAPPED_W-1:0] res_mapped;
  logic                         res_inuse;

  logic                         in_fire;
  logic                         out_free;
  pfa_pkg::cmd_t                in_cmd;
  logic [pfa_pkg::FQ_W-1:0]     in_fq;
  logic                         in_fq_ok;
  logic                         found;
  logic                         none;
  logic                         issue;
  logic [pfa_pkg::BYTE_W-1:0]   slot_lut [pfa_pkg::PID_COUNT];
  logic [AW-1:0]                slot_addr;
  logic [pfa_pkg::BYTE_W-1:0]   ent_frame;
  logic [pfa_pkg::COUNT_W-1:0]  ent_off;
  logic [PROD_W-1:0]            ent_sum;
  logic [AW-1:0]                ent_addr;

  logic [AW-1:0]                mem_raddr;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [pfa_pkg::BYTE_W-1:0]   mem_wdata;
  logic [pfa_pkg::BYTE_W-1:0]   mem_rdata;
  logic                         mem_ready;

  pfa_mem #(
    .RAM_BYTES (RAM_BYTES),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (mem_raddr),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata),
    .ready   (mem_ready)
  );

  // Process slot index table, worked out at elaboration
  for (genvar gi = 0; gi < pfa_pkg::PID_COUNT; gi++) begin : g_slot
    assign slot_lut[gi] = pfa_pkg::BYTE_W'(gi % PROCESS_SLOTS);
  end

  // Decode the incoming word and handshake
  assign in_cmd   = pfa_pkg::cmd_t'(s_axis_tdata[1:0]);
  assign in_fq    = s_axis_tdata[26:21];
  assign in_fq_ok = {1'b0, in_fq} < (pfa_pkg::FQ_W + 1)'(FRAME_COUNT);
  assign s_axis_tready = (state == pfa_pkg::ST_IDLE) && mem_ready;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Free-map scan: one read per cycle until a hit, hit when a returned mark is zero
  assign issue = scan_f < SW'(FRAME_COUNT);
  assign found = (state == pfa_pkg::ST_SCAN) && rd_v && (mem_rdata == '0);
  assign none  = (state == pfa_pkg::ST_SCAN) && !issue && (!rd_v || (mem_rdata != '0));

  // Byte addresses of a process slot and of a table entry
  assign slot_addr = AW'({1'b0, slot_lut[pid_reg]} + (pfa_pkg::BYTE_W + 1)'(FRAME_COUNT));
  assign ent_frame = (state == pfa_pkg::ST_LK_TABLE) ? mem_rdata : table_reg;
  assign ent_off   = (state == pfa_pkg::ST_LK_TABLE) ? {1'b0, vpage_reg} : res_granted;
  assign ent_sum   = PROD_W'(ent_frame) * PROD_W'(PAGE_BYTES) + PROD_W'(ent_off);
  assign ent_addr  = AW'(ent_sum);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pfa_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            pfa_pkg::CMD_NEW:    state_next = pfa_pkg::ST_SCAN;
            pfa_pkg::CMD_LOOKUP: state_next = pfa_pkg::ST_LK_SLOT;
            pfa_pkg::CMD_QUERY:  state_next = in_fq_ok ? pfa_pkg::ST_Q_READ : pfa_pkg::ST_DONE;
            default:             state_next = pfa_pkg::ST_DONE;
          endcase
        end
      end
      pfa_pkg::ST_SCAN: begin
        if (found) begin
          state_next = phase_data ? pfa_pkg::ST_WR_ENTRY : pfa_pkg::ST_WR_SLOT;
        end else if (none) begin
          state_next = pfa_pkg::ST_DONE;
        end
      end
      pfa_pkg::ST_WR_SLOT: begin
        state_next = (count_reg == '0) ? pfa_pkg::ST_DONE : pfa_pkg::ST_SCAN;
      end
      pfa_pkg::ST_WR_ENTRY: begin
        state_next = (res_granted + 7'd1 == count_reg) ? pfa_pkg::ST_DONE : pfa_pkg::ST_SCAN;
      end
      pfa_pkg::ST_LK_SLOT:  state_next = pfa_pkg::ST_LK_TABLE;
      pfa_pkg::ST_LK_TABLE: state_next = pfa_pkg::ST_LK_MAP;
      pfa_pkg::ST_LK_MAP:   state_next = pfa_pkg::ST_DONE;
      pfa_pkg::ST_Q_READ:   state_next = pfa_pkg::ST_Q_CAP;
      pfa_pkg::ST_Q_CAP:    state_next = pfa_pkg::ST_DONE;
      pfa_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pfa_pkg::ST_IDLE;
        end
      end
      default: state_next = pfa_pkg::ST_IDLE;
    endcase
  end

  // Memory read and write selection per state
  always_comb begin
    mem_raddr = AW'(scan_f);
    mem_we    = 1'b0;
    mem_waddr = AW'(rd_f);
    mem_wdata = pfa_pkg::USED_MARK;
    case (state)
      pfa_pkg::ST_SCAN: begin
        mem_we = found;
      end
      pfa_pkg::ST_WR_SLOT: begin
        mem_we    = 1'b1;
        mem_waddr = slot_addr;
        mem_wdata = table_reg;
      end
      pfa_pkg::ST_WR_ENTRY: begin
        mem_we    = 1'b1;
        mem_waddr = ent_addr;
        mem_wdata = pfa_pkg::BYTE_W'(data_frame);
      end
      pfa_pkg::ST_LK_SLOT:  mem_raddr = slot_addr;
      pfa_pkg::ST_LK_TABLE: mem_raddr = ent_addr;
      pfa_pkg::ST_Q_READ:   mem_raddr = AW'(fq_reg);
      default: ;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command fields and result build-up
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      case (state)
        pfa_pkg::ST_IDLE: begin
          rd_v <= 1'b0;
          if (in_fire) begin
            pid_reg     <= s_axis_tdata[7:2];
            count_reg   <= s_axis_tdata[14:8];
            vpage_reg   <= s_axis_tdata[20:15];
            fq_reg      <= in_fq;
            phase_data  <= 1'b0;
            scan_f      <= '0;
            res_status  <= pfa_pkg::STATUS_OK;
            res_tframe  <= '0;
            res_granted <= '0;
            res_mapped  <= '0;
            res_inuse   <= 1'b0;
          end
        end
        pfa_pkg::ST_SCAN: begin
          if (found) begin
            // Frames below a hit stay in use; resume just past it
            scan_f <= rd_f + SW'(1);
            rd_v   <= 1'b0;
            if (phase_data) begin
              data_frame <= rd_f;
            end else begin
              table_reg  <= pfa_pkg::BYTE_W'(rd_f);
              res_tframe <= pfa_pkg::TFRAME_W'(rd_f);
            end
          end else begin
            rd_v <= issue;
            rd_f <= scan_f;
            if (issue) begin
              scan_f <= scan_f + SW'(1);
            end
            if (none) begin
              res_status <= phase_data ? pfa_pkg::STATUS_NO_DATA : pfa_pkg::STATUS_NO_TABLE;
            end
          end
        end
        pfa_pkg::ST_WR_SLOT:  phase_data <= 1'b1;
        pfa_pkg::ST_WR_ENTRY: res_granted <= res_granted + 7'd1;
        pfa_pkg::ST_LK_TABLE: begin
          table_reg  <= mem_rdata;
          res_tframe <= mem_rdata[pfa_pkg::TFRAME_W-1:0];
        end
        pfa_pkg::ST_LK_MAP: res_mapped <= mem_rdata;
        pfa_pkg::ST_Q_CAP:  res_inuse  <= (mem_rdata != '0);
        default: ;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == pfa_pkg::ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {res_inuse, res_mapped, res_granted, res_tframe, res_status};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  `PFA_ASSERT_IMPLIES(a_no_accept_clearing, s_axis_tvalid && s_axis_tready, mem_ready, "word accepted during RAM sweep")
  `PFA_ASSERT_IMPLIES(a_scan_exclusive, state == pfa_pkg::ST_SCAN, !(found && none), "scan hit and miss together")
  `PFA_ASSERT_IMPLIES(a_scan_in_range, rd_v, rd_f < SW'(FRAME_COUNT), "scan read beyond free map")
  `PFA_ASSERT_IMPLIES(a_granted_bound, state == pfa_pkg::ST_DONE, res_granted <= count_reg, "more pages granted than asked")
  `PFA_ASSERT_NEXT(a_result_loaded, (state == pfa_pkg::ST_DONE) && out_free, m_axis_tvalid, "finished result not presented")

endmodule

>>> sv/pfa_mem.sv
// Byte RAM of the allocator with a clearing sweep after reset.
module pfa_mem #(
  parameter int RAM_BYTES = 16384,
  parameter int AW        = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pfa_pkg::BYTE_W-1:0]  wr_data,
  output logic [pfa_pkg::BYTE_W-1:0]  rd_data,
  output logic                        ready
);

  logic [pfa_pkg::BYTE_W-1:0] mem [RAM_BYTES];
  logic                       clearing;
  logic [AW-1:0]              clr_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [pfa_pkg::BYTE_W-1:0] mem_wd;

  // Sweep every byte once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(RAM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Clear writes zero everywhere but mark frame 0 in use
  always_comb begin
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = (clr_addr == '0) ? pfa_pkg::USED_MARK : '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  assign ready = !clearing;

endmodule

>>> tb/page_frame_allocator_unit_tb.sv
// Testbench for the page frame allocator: directed table, random commands, predicted results.
`timescale 1ns / 100ps

module page_frame_allocator_unit_tb;
  import pfa_pkg::*;

  localparam int PAGE_BYTES    = 256;
  localparam int FRAME_COUNT   = 64;
  localparam int PROCESS_SLOTS = 64;
  localparam int RAM_BYTES     = 16384;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] NO_FRAME   = 8'hff;

  localparam int RANDOM_ITEMS = 117;
  // Covers the post-reset RAM sweep plus the longest new-process command
  localparam int STALL_LIMIT  = 60000;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_MAX   = 10;

  // Command word, last field in the lowest bits
  typedef struct packed {
    logic [4:0]          pad;
    logic [FQ_W-1:0]     fq;
    logic [VPAGE_W-1:0]  vpage;
    logic [COUNT_W-1:0]  req_pages;
    logic [PID_W-1:0]    pid;
    logic [CMD_W-1:0]    cmd;
  } cmd_word_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic                frame_in_use;
    logic [MAPPED_W-1:0] mapped_frame;
    logic [COUNT_W-1:0]  pages_granted;
    logic [TFRAME_W-1:0] table_frame;
    logic [STATUS_W-1:0] status;
  } frame_result_t;

  typedef struct {
    cmd_word_t     word;
    bit            typed;
    frame_result_t result;
  } drill_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  logic [BYTE_W-1:0] ram_image [RAM_BYTES];
  frame_result_t     pending_results [$];
  drill_row_t        drill_rows [$];
  logic [PID_W-1:0]  live_pids [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;

  page_frame_allocator_unit #(
    .PAGE_BYTES   (PAGE_BYTES),
    .FRAME_COUNT  (FRAME_COUNT),
    .PROCESS_SLOTS(PROCESS_SLOTS),
    .RAM_BYTES    (RAM_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Byte address of an offset within a frame, wrapped to the RAM size
  function automatic int byte_addr(input int frame, input int offset);
    return (frame * PAGE_BYTES + offset) % RAM_BYTES;
  endfunction

  function automatic int slot_addr(input int pid);
    return (FRAME_COUNT + pid % PROCESS_SLOTS) % RAM_BYTES;
  endfunction

  // First-free scan of the free map; marks the frame it returns
  function automatic logic [BYTE_W-1:0] grab_free_frame();
    for (int f = 0; f < FRAME_COUNT; f++) begin
      if (ram_image[f % RAM_BYTES] == '0) begin
        ram_image[f % RAM_BYTES] = USED_MARK;
        return f[BYTE_W-1:0];
      end
    end
    return NO_FRAME;
  endfunction

  // Apply one command to the RAM image and return its result word
  function automatic frame_result_t predict_frame_result(input cmd_word_t w);
    frame_result_t r;
    logic [BYTE_W-1:0] tbl;
    logic [BYTE_W-1:0] dat;
    r = '0;
    case (w.cmd)
      CMD_NEW: begin
        tbl = grab_free_frame();
        if (tbl == NO_FRAME) begin
          r.status = STATUS_NO_TABLE;
        end else begin
          ram_image[slot_addr(w.pid)] = tbl;
          r.table_frame = tbl[TFRAME_W-1:0];
          for (int x = 0; x < w.req_pages; x++) begin
            dat = grab_free_frame();
            if (dat == NO_FRAME) begin
              r.status = STATUS_NO_DATA;
              break;
            end
            ram_image[byte_addr(tbl, x)] = dat;
            r.pages_granted = r.pages_granted + 7'd1;
          end
        end
      end
      CMD_LOOKUP: begin
        tbl = ram_image[slot_addr(w.pid)];
        r.table_frame  = tbl[TFRAME_W-1:0];
        r.mapped_frame = ram_image[byte_addr(tbl, w.vpage)];
      end
      CMD_QUERY: begin
        if (w.fq < FRAME_COUNT)
          r.frame_in_use = (ram_image[w.fq % RAM_BYTES] != '0);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_word_t make_word(input logic [CMD_W-1:0] cmd, input int pid,
                                          input int cnt, input int vpage, input int fq);
    cmd_word_t w;
    w = '0;
    w.cmd       = cmd;
    w.pid       = pid[PID_W-1:0];
    w.req_pages = cnt[COUNT_W-1:0];
    w.vpage     = vpage[VPAGE_W-1:0];
    w.fq        = fq[FQ_W-1:0];
    return w;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input int pid, input int cnt,
                         input int vpage, input int fq, input bit typed,
                         input int st, input int tf, input int gr, input int mf,
                         input int iu);
    drill_row_t row;
    row.word   = make_word(cmd, pid, cnt, vpage, fq);
    row.typed  = typed;
    row.result = '{frame_in_use: iu[0], mapped_frame: mf[MAPPED_W-1:0],
                   pages_granted: gr[COUNT_W-1:0], table_frame: tf[TFRAME_W-1:0],
                   status: st[STATUS_W-1:0]};
    drill_rows.push_back(row);
  endtask

  // Drive one command word; queue its expected result once it is accepted
  task automatic send_command(input cmd_word_t w, input bit typed,
                              input frame_result_t typed_res);
    frame_result_t predicted;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = w;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_frame_result(w);
    pending_results.push_back(typed ? typed_res : predicted);
    if (w.cmd == CMD_NEW && predicted.status == STATUS_OK)
      live_pids.push_back(w.pid);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // Receiver stalls, redrawn each cycle
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.table_frame !== want.table_frame ||
            got.pages_granted !== want.pages_granted ||
            got.mapped_frame !== want.mapped_frame ||
            got.frame_in_use !== want.frame_in_use) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"mismatch: expected status %0d table %0d granted %0d mapped %0d ",
                      "in_use %0d, got status %0d table %0d granted %0d mapped %0d in_use %0d"},
                     want.status, want.table_frame, want.pages_granted,
                     want.mapped_frame, want.frame_in_use, got.status, got.table_frame,
                     got.pages_granted, got.mapped_frame, got.frame_in_use);
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("page_frame_allocator_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cmd_word_t w;
    frame_result_t none;
    int pick;
    int pid;
    int cnt;
    int vpage;
    none = '0;
    for (int a = 0; a < RAM_BYTES; a++) ram_image[a] = '0;
    ram_image[0] = USED_MARK;

    // Directed rows; typed expectations where they follow from reset or errors
    add_row(CMD_QUERY,  0,  0,  0,  0, 1, STATUS_OK, 0, 0, 0, 1);
    add_row(CMD_QUERY,  0,  0,  0, 63, 1, STATUS_OK, 0, 0, 0, 0);
    // unknown process reads entries of frame 0, i.e. the free map
    add_row(CMD_LOOKUP, 5,  0,  0,  0, 1, STATUS_OK, 0, 0, 1, 0);
    add_row(CMD_LOOKUP, 63, 0, 63,  0, 1, STATUS_OK, 0, 0, 0, 0);
    add_row(CMD_UNUSED, 63, 64, 63, 63, 1, STATUS_OK, 0, 0, 0, 0);
    add_row(CMD_NEW,    0,  0,  0,  0, 1, STATUS_OK, 1, 0, 0, 0);
    add_row(CMD_NEW,    63, 3,  0,  0, 1, STATUS_OK, 2, 3, 0, 0);
    add_row(CMD_LOOKUP, 63, 0,  2,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 63, 0, 63,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 0,  0,  0,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY,  0,  0,  0,  5, 0, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY,  0,  0,  0,  6, 0, 0, 0, 0, 0, 0);
    // reuse of a process id overwrites its slot
    add_row(CMD_NEW,    0,  2,  0,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 0,  0,  1,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 17, 0,  1,  0, 0, 0, 0, 0, 0, 0);
    // largest request runs out of data frames and keeps the partial table
    add_row(CMD_NEW,    42, 64, 0,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY,  0,  0,  0, 63, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 42, 0, 53,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 42, 0, 54,  0, 0, 0, 0, 0, 0, 0);
    // free map full: no frame left for a page table
    add_row(CMD_NEW,    1,  1,  0,  0, 1, STATUS_NO_TABLE, 0, 0, 0, 0);
    add_row(CMD_NEW,    2, 64,  0,  0, 1, STATUS_NO_TABLE, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 1,  0,  0,  0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_UNUSED, 0,  0,  0,  0, 1, STATUS_OK, 0, 0, 0, 0);

    // Hold reset, release at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (drill_rows[i])
      send_command(drill_rows[i].word, drill_rows[i].typed, drill_rows[i].result);

    // Random commands, with idling phases in quarters of the run
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n * 4) / RANDOM_ITEMS)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin sender_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      pick  = $urandom_range(99);
      pid   = $urandom_range(63);
      vpage = $urandom_range(63);
      cnt   = ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(4);
      if (live_pids.size() != 0 && $urandom_range(9) < 7) begin
        pid   = live_pids[$urandom_range(live_pids.size() - 1)];
        vpage = ($urandom_range(1) == 0) ? $urandom_range(7) : vpage;
      end
      if (pick < 15)
        w = make_word(CMD_NEW, pid, cnt, $urandom_range(63), $urandom_range(63));
      else if (pick < 65)
        w = make_word(CMD_LOOKUP, pid, $urandom_range(64), vpage, $urandom_range(63));
      else if (pick < 97)
        w = make_word(CMD_QUERY, pid, $urandom_range(64), vpage, $urandom_range(63));
      else
        w = make_word(CMD_UNUSED, pid, cnt, vpage, $urandom_range(63));
      send_command(w, 1'b0, none);
    end

    // Drain outstanding results, then allow a quiet tail
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    fail_count = fail_count + pending_results.size();
    if (fail_count == 0)
      $display("page_frame_allocator_unit_tb: PASS");
    else
      $display("page_frame_allocator_unit_tb: FAIL");
    $finish;
  end

endmodule
